// ----- hdl/tgs_pkg.sv -----
// Package with payload types and constants for the tree group shrink block.
`timescale 1ns / 1ps
`default_nettype none
package tgs_pkg;
  localparam int unsigned MaxLenDefault = 64;
  localparam int unsigned MaxGroupsDefault = 64;
  localparam logic [6:0] LenReset = 7'd64;

  localparam logic [1:0] OpLoadElem = 2'd0;
  localparam logic [1:0] OpLoadGroup = 2'd1;
  localparam logic [1:0] OpRun = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatBadRoot = 2'd1;
  localparam logic [1:0] StatBadRange = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] elem_index;
    logic signed [31:0] elem_value;
    logic [5:0] group_slot;
    logic signed [7:0] group_start;
    logic signed [7:0] group_end;
    logic [30:0] group_weight;
    logic [6:0] group_count;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [5:0] out_index;
    logic last;
    logic [1:0] status;
  } out_word_t;

  // Commands to the shared iterative unit.
  typedef struct packed {
    logic start;
    logic is_div;
    logic [69:0] a;
    logic [36:0] b;
  } alu_cmd_t;
endpackage
`default_nettype wire

// ----- hdl/tgs_alu.sv -----
// Shared bit-serial unit: floor square root of a 70-bit value or a 32-bit fraction divide.
`timescale 1ns / 1ps
`default_nettype none
module tgs_alu (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire tgs_pkg::alu_cmd_t cmd_i,
  output logic done_o,
  output logic [36:0] res_o
);
  import tgs_pkg::*;

  logic [37:0] rem_q, rem_d;
  logic [69:0] src_q, src_d;
  logic [36:0] root_q, root_d, div_q;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d, div_mode_q, div_mode_d, done_d;
  logic [39:0] trial;
  logic [37:0] dtrial;

  // Restoring square root consumes two source bits per step;
  // the divide produces one quotient bit per step.
  always_comb begin
    rem_d = rem_q;
    src_d = src_q;
    root_d = root_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    div_mode_d = div_mode_q;
    done_d = 1'b0;
    trial = '0;
    dtrial = '0;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      div_mode_d = cmd_i.is_div;
      src_d = cmd_i.a;
      rem_d = cmd_i.is_div ? {1'b0, cmd_i.a[36:0]} : '0;
      root_d = '0;
      cnt_d = cmd_i.is_div ? 6'd32 : 6'd35;
    end else if (busy_q) begin
      if (div_mode_q) begin
        dtrial = {rem_q[36:0], 1'b0};
        if (dtrial >= {1'b0, div_q}) begin
          rem_d = dtrial - {1'b0, div_q};
          root_d = {root_q[35:0], 1'b1};
        end else begin
          rem_d = dtrial;
          root_d = {root_q[35:0], 1'b0};
        end
      end else begin
        trial = {1'b0, rem_q[36:0], src_q[69:68]} - {3'd0, root_q[34:0], 2'b01};
        src_d = {src_q[67:0], 2'b00};
        if (!trial[39]) begin
          rem_d = trial[37:0];
          root_d = {root_q[35:0], 1'b1};
        end else begin
          rem_d = {rem_q[35:0], src_q[69:68]};
          root_d = {root_q[35:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    src_q <= src_d;
    root_q <= root_d;
    cnt_q <= cnt_d;
    div_mode_q <= div_mode_d;
    if (cmd_i.start) div_q <= cmd_i.b;
  end

  assign res_o = root_q;
endmodule
`default_nettype wire

// ----- hdl/tree_group_shrink_top.sv -----
// Top level of the tree group shrink block: stores, sequencer and shared unit.
// A load word is taken while idle. A run checks each group, then copies or soft-thresholds the
// vector, then per group sums the squares and, when the group is scaled, runs the square root
// and the division before it scales or zeroes the elements, and at the end emits the words.
// Results leave on out_valid_o and cannot be stalled.
// Reset clears control state and sets the length register to 64; stores are undefined.
`timescale 1ns / 1ps
`default_nettype none
module tree_group_shrink_top #(
  parameter int unsigned MaxLen = tgs_pkg::MaxLenDefault,
  parameter int unsigned MaxGroups = tgs_pkg::MaxGroupsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic busy,
  input  wire tgs_pkg::in_word_t in_word_i,
  input  wire logic cfg_valid_i,
  output logic cfg_ready_o,
  input  wire logic [6:0] cfg_data_i,
  output logic out_valid_o,
  output tgs_pkg::out_word_t out_word_o
);
  import tgs_pkg::*;

  localparam int unsigned LW = $clog2(MaxLen);
  localparam int unsigned GW = (MaxGroups > 1) ? $clog2(MaxGroups) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_RD, S_CHK, S_ROOT_RD, S_ROOT, S_GRP_RD, S_GRP, S_SUM_RD, S_SUM,
    S_SQRT, S_DIV, S_SCL_RD, S_SCL, S_EMIT_RD, S_EMIT
  } state_e;

  state_e state_q;
  logic [6:0] len_q;
  logic [7:0] n_q, cnt_q;
  logic [8:0] gi_q;
  logic first_q;
  logic [6:0] j_q;
  logic signed [7:0] s_q, e_q;
  logic [30:0] lam_q;
  logic [69:0] acc_q;
  logic [32:0] ratio_q;
  logic scale_q;
  logic [1:0] err_q;

  // Stores: loaded vector, working vector and group descriptors.
  logic [31:0] vmem [MaxLen];
  logic [31:0] xmem [MaxLen];
  logic [7:0] smem [MaxGroups];
  logic [7:0] emem [MaxGroups];
  logic [30:0] wmem [MaxGroups];
  logic [31:0] vrd_q, xrd_q;
  logic [7:0] srd_q, erd_q;
  logic [30:0] wrd_q;
  logic [LW-1:0] vra;
  logic [GW-1:0] gra;
  logic [GW-1:0] gwa;
  logic vwe;
  logic [LW-1:0] vwa;
  logic [31:0] vwd;
  logic xwe;
  logic [31:0] xwd;

  alu_cmd_t cmd;
  logic alu_done;
  logic [36:0] alu_res;

  tgs_alu u_alu (.clk_i, .rst_ni, .cmd_i(cmd), .done_o(alu_done), .res_o(alu_res));

  assign cfg_ready_o = (state_q == S_IDLE);
  assign busy = (state_q != S_IDLE);

  // Element work values.
  logic signed [32:0] v33;
  logic [31:0] mag;
  logic [63:0] sq;
  logic signed [33:0] thr_val;
  logic [63:0] prod;
  logic [31:0] scaled;
  logic [31:0] soft_res;
  logic [61:0] lam_sq;
  logic grp_big;
  logic sum_end;
  assign v33 = {vrd_q[31], vrd_q};
  assign mag = xrd_q[31] ? (32'd0 - xrd_q) : xrd_q;
  assign sq = mag * mag;
  assign prod = mag * ratio_q;
  assign scaled = xrd_q[31] ? (32'd0 - prod[63:32]) : prod[63:32];
  assign lam_sq = lam_q * lam_q;
  assign grp_big = (acc_q > {8'd0, lam_sq});
  assign sum_end = (j_q > 7'(e_q) - 7'd1);
  always_comb begin
    thr_val = '0;
    if (v33 > $signed({2'b0, lam_q})) thr_val = v33 - $signed({2'b0, lam_q});
    else if (v33 < -$signed({2'b0, lam_q})) thr_val = v33 + $signed({2'b0, lam_q});
    if (thr_val > 34'sd2147483647) soft_res = 32'h7fffffff;
    else if (thr_val < -34'sd2147483648) soft_res = 32'h80000000;
    else soft_res = thr_val[31:0];
  end

  logic bad_range;
  logic signed [8:0] sx, ex;
  assign sx = {srd_q[7], srd_q};
  assign ex = {erd_q[7], erd_q};
  assign bad_range = (sx <= ex) && ((sx < 9'sd1) || (ex > $signed({1'b0, n_q})));

  // Read addresses and write ports for the vector and group stores.
  assign vwa = in_word_i.elem_index[LW-1:0];
  assign vwd = in_word_i.elem_value;
  assign gwa = GW'(in_word_i.group_slot);
  always_comb begin
    vra = j_q[LW-1:0];
    gra = gi_q[GW-1:0];
    vwe = (state_q == S_IDLE) && start && (in_word_i.op == OpLoadElem) &&
          ({2'b0, in_word_i.elem_index} < 8'(MaxLen));
    xwe = 1'b0;
    xwd = vrd_q;
    if (state_q == S_ROOT) begin
      xwe = 1'b1;
      xwd = first_q ? soft_res : vrd_q;
    end else if (state_q == S_SCL) begin
      xwe = 1'b1;
      xwd = scale_q ? scaled : 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vwe) vmem[vwa] <= vwd;
    if (xwe) xmem[vra] <= xwd;
    if (state_q == S_IDLE && start && in_word_i.op == OpLoadGroup &&
        {3'b0, in_word_i.group_slot} < 9'(MaxGroups)) begin
      smem[gwa] <= in_word_i.group_start;
      emem[gwa] <= in_word_i.group_end;
      wmem[gwa] <= in_word_i.group_weight;
    end
    vrd_q <= vmem[vra];
    xrd_q <= xmem[vra];
    srd_q <= smem[gra];
    erd_q <= emem[gra];
    wrd_q <= wmem[gra];
  end

  // Shared unit command: sqrt of the sum, then the ratio divide.
  always_comb begin
    cmd = '0;
    if (state_q == S_SUM && sum_end && grp_big) begin
      cmd.start = 1'b1;
      cmd.a = acc_q;
    end else if (state_q == S_SQRT && alu_done) begin
      cmd.start = 1'b1;
      cmd.is_div = 1'b1;
      cmd.a = {33'd0, alu_res - {6'd0, lam_q}};
      cmd.b = alu_res;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q <= LenReset;
      out_valid_o <= 1'b0;
      out_word_o <= '0;
      n_q <= '0;
      cnt_q <= '0;
      gi_q <= '0;
      first_q <= 1'b0;
      j_q <= '0;
      s_q <= '0;
      e_q <= '0;
      lam_q <= '0;
      acc_q <= '0;
      ratio_q <= '0;
      scale_q <= 1'b0;
      err_q <= StatOk;
    end else begin
      out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) len_q <= cfg_data_i;
          if (start && in_word_i.op == OpRun) begin
            n_q <= (len_q == 7'd0) ? 8'd1 : ((len_q > 7'(MaxLen)) ? 8'(MaxLen) : {1'b0, len_q});
            cnt_q <= (9'(in_word_i.group_count) > 9'(MaxGroups)) ? 8'(MaxGroups)
                     : {1'b0, in_word_i.group_count};
            gi_q <= '0;
            first_q <= 1'b0;
            err_q <= StatOk;
            state_q <= S_CHK_RD;
          end
        end
        S_CHK_RD: begin
          if ({1'b0, gi_q} >= {2'b0, cnt_q}) begin
            gi_q <= first_q ? 9'd1 : 9'd0;
            j_q <= '0;
            state_q <= S_ROOT_RD;
          end else state_q <= S_CHK;
        end
        S_CHK: begin
          if (gi_q == 9'd0 && srd_q == 8'hff) begin
            if (erd_q != 8'hff) begin
              err_q <= StatBadRoot;
              state_q <= S_EMIT;
            end else begin
              first_q <= 1'b1;
              gi_q <= gi_q + 9'd1;
              state_q <= S_CHK_RD;
            end
          end else if (bad_range) begin
            err_q <= StatBadRange;
            state_q <= S_EMIT;
          end else begin
            gi_q <= gi_q + 9'd1;
            state_q <= S_CHK_RD;
          end
          if (gi_q == 9'd0) lam_q <= wrd_q;
        end
        // The working copy takes each element, soft-thresholded when there is a root.
        S_ROOT_RD: state_q <= S_ROOT;
        S_ROOT: begin
          if (j_q + 7'd1 >= n_q[6:0]) state_q <= S_GRP_RD;
          else state_q <= S_ROOT_RD;
          j_q <= j_q + 7'd1;
        end
        S_GRP_RD: begin
          if ({1'b0, gi_q} >= {2'b0, cnt_q}) begin
            j_q <= '0;
            state_q <= S_EMIT_RD;
          end else state_q <= S_GRP;
        end
        S_GRP: begin
          s_q <= srd_q;
          e_q <= erd_q;
          lam_q <= wrd_q;
          acc_q <= '0;
          if ($signed(srd_q) > $signed(erd_q)) begin
            gi_q <= gi_q + 9'd1;
            state_q <= S_GRP_RD;
          end else begin
            j_q <= 7'(srd_q) - 7'd1;
            state_q <= S_SUM_RD;
          end
        end
        S_SUM_RD: state_q <= S_SUM;
        S_SUM: begin
          if (sum_end) begin
            // Whole group summed; compare against weight squared.
            if (grp_big) begin
              state_q <= S_SQRT;
            end else begin
              ratio_q <= '0;
              scale_q <= 1'b0;
              j_q <= 7'(s_q) - 7'd1;
              state_q <= S_SCL_RD;
            end
          end else begin
            acc_q <= acc_q + {6'd0, sq};
            j_q <= j_q + 7'd1;
            state_q <= (j_q + 7'd1 > 7'(e_q) - 7'd1) ? S_SUM : S_SUM_RD;
          end
        end
        S_SQRT: if (alu_done) begin
          state_q <= S_DIV;
        end
        S_DIV: if (alu_done) begin
          ratio_q <= (lam_q == 31'd0) ? 33'h1_0000_0000 : alu_res[32:0];
          scale_q <= 1'b1;
          j_q <= 7'(s_q) - 7'd1;
          state_q <= S_SCL_RD;
        end
        S_SCL_RD: state_q <= S_SCL;
        S_SCL: begin
          j_q <= j_q + 7'd1;
          if (j_q + 7'd1 > 7'(e_q) - 7'd1) begin
            gi_q <= gi_q + 9'd1;
            state_q <= S_GRP_RD;
          end else state_q <= S_SCL_RD;
        end
        S_EMIT_RD: state_q <= S_EMIT;
        S_EMIT: begin
          out_valid_o <= 1'b1;
          if (err_q != StatOk) begin
            out_word_o <= '{out_value: '0, out_index: '0, last: 1'b1, status: err_q};
            state_q <= S_IDLE;
          end else begin
            out_word_o <= '{out_value: xrd_q, out_index: j_q[5:0],
                            last: (j_q + 7'd1 == n_q[6:0]), status: StatOk};
            j_q <= j_q + 7'd1;
            state_q <= (j_q + 7'd1 == n_q[6:0]) ? S_IDLE : S_EMIT_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the tree group shrink block, with a queue-fed driver and a monitor.
`timescale 1ns / 1ps
module tb_top;
  import tgs_pkg::*;

  localparam int unsigned CycleLimit = 3000000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_word_t in_word_i;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [6:0] cfg_data_i;
  logic out_valid_o;
  out_word_t out_word_o;

  tree_group_shrink_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .in_word_i(in_word_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_word_o(out_word_o)
  );

  // Shadow of the block's stores and length register.
  logic [31:0] vec_mem[64];
  logic [7:0] gstart_mem[64];
  logic [7:0] gend_mem[64];
  logic [30:0] gweight_mem[64];
  logic [6:0] len_reg;

  in_word_t cmd_q[$];
  out_word_t shrunk_q[$];
  int unsigned fails;
  int unsigned cycles;
  bit steady;
  int cur_len;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void push_error(logic [1:0] code);
    out_word_t o;
    o = '0;
    o.last = 1'b1;
    o.status = code;
    shrunk_q = {shrunk_q, o};
  endfunction

  // Computes the words that one accepted command produces.
  function automatic void predict_shrink(in_word_t w);
    int n, cnt, first, s, e, i, j, k;
    logic [31:0] x[64];
    longint v, lam;
    longint unsigned m;
    logic [79:0] sum, lam2, c;
    logic [39:0] r, d, rem;
    logic [32:0] q;
    logic [95:0] prod;
    logic [31:0] res;
    out_word_t o;
    if (w.op == OpLoadElem) begin
      vec_mem[w.elem_index] = w.elem_value;
      return;
    end
    if (w.op == OpLoadGroup) begin
      gstart_mem[w.group_slot] = w.group_start;
      gend_mem[w.group_slot] = w.group_end;
      gweight_mem[w.group_slot] = w.group_weight;
      return;
    end
    if (w.op != OpRun) return;
    n = (len_reg < 1) ? 1 : ((len_reg > 64) ? 64 : int'(len_reg));
    cnt = (w.group_count > 64) ? 64 : int'(w.group_count);
    first = 0;
    if (cnt >= 1 && $signed(gstart_mem[0]) == -8'sd1) begin
      if ($signed(gend_mem[0]) != -8'sd1) begin
        push_error(StatBadRoot);
        return;
      end
      first = 1;
    end
    for (i = first; i < cnt; i++) begin
      s = $signed(gstart_mem[i]);
      e = $signed(gend_mem[i]);
      if (s <= e && (s < 1 || e > n)) begin
        push_error(StatBadRange);
        return;
      end
    end
    // Soft threshold by the root weight, saturating.
    for (j = 0; j < n; j++) begin
      x[j] = vec_mem[j];
      if (first == 1) begin
        v = longint'($signed(vec_mem[j]));
        lam = longint'(gweight_mem[0]);
        if (v > lam) v = v - lam;
        else if (v < -lam) v = v + lam;
        else v = 0;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        x[j] = v[31:0];
      end
    end
    // Scale or zero each later group in table order.
    for (i = first; i < cnt; i++) begin
      s = $signed(gstart_mem[i]);
      e = $signed(gend_mem[i]);
      if (s > e) continue;
      lam = longint'(gweight_mem[i]);
      sum = '0;
      for (j = s - 1; j < e; j++) begin
        v = longint'($signed(x[j]));
        m = (v < 0) ? -v : v;
        sum += {16'b0, m * m};
      end
      lam2 = {16'b0, lam * lam};
      if (sum > lam2) begin
        r = '0;
        for (k = 36; k >= 0; k--) begin
          c = {40'b0, r | (40'b1 << k)};
          if (c * c <= sum) r = c[39:0];
        end
        if (lam == 0) begin
          q = 33'h1_0000_0000;
        end else begin
          d = r - lam[39:0];
          rem = d;
          q = '0;
          for (k = 0; k < 32; k++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= r) begin
              rem = rem - r;
              q[0] = 1'b1;
            end
          end
        end
        for (j = s - 1; j < e; j++) begin
          v = longint'($signed(x[j]));
          m = (v < 0) ? -v : v;
          prod = {32'b0, m} * {63'b0, q};
          res = prod[63:32];
          x[j] = (v < 0) ? -res : res;
        end
      end else begin
        for (j = s - 1; j < e; j++) x[j] = '0;
      end
    end
    for (j = 0; j < n; j++) begin
      o.out_value = x[j];
      o.out_index = j[5:0];
      o.last = (j == n - 1);
      o.status = StatOk;
      shrunk_q = {shrunk_q, o};
    end
  endfunction

  // Driver: presents queued commands and predicts each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      in_word_i <= '0;
    end else begin
      if (start && !busy) predict_shrink(in_word_i);
      if (!start || !busy) begin
        if (cmd_q.size() > 0 && (steady || $urandom_range(0, 99) >= 7)) begin
          start <= 1'b1;
          in_word_i <= cmd_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (shrunk_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_word_o);
        fails++;
      end else begin
        if (out_word_o !== shrunk_q[0]) begin
          $display("%0t: mismatch expected %h actual %h", $time, shrunk_q[0], out_word_o);
          fails++;
        end
        void'(shrunk_q.pop_front());
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic in_word_t noise_word();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[99:0];
  endfunction

  task automatic load_elem(int idx, logic [31:0] val);
    in_word_t w;
    w = noise_word();
    w.op = OpLoadElem;
    w.elem_index = idx[5:0];
    w.elem_value = val;
    cmd_q = {cmd_q, w};
  endtask

  task automatic load_group(int slot, int gs, int ge, logic [30:0] wt);
    in_word_t w;
    w = noise_word();
    w.op = OpLoadGroup;
    w.group_slot = slot[5:0];
    w.group_start = gs[7:0];
    w.group_end = ge[7:0];
    w.group_weight = wt;
    cmd_q = {cmd_q, w};
  endtask

  task automatic run_shrink(int cnt);
    in_word_t w;
    w = noise_word();
    w.op = OpRun;
    w.group_count = cnt[6:0];
    cmd_q = {cmd_q, w};
  endtask

  function automatic logic [30:0] pick_weight();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return 31'($urandom());
    return 31'($urandom_range(0, 32'h0004_0000));
  endfunction

  // Mostly well-formed descriptors, with some empty, bad and root ones.
  task automatic random_group(int slot);
    int sel, gs, ge;
    sel = $urandom_range(0, 99);
    if (slot == 0 && sel < 35) begin
      load_group(0, -1, -1, pick_weight());
    end else if (slot == 0 && sel < 38) begin
      load_group(0, -1, $urandom_range(0, 64), pick_weight());
    end else if (sel < 45) begin
      gs = $urandom_range(1, 64);
      load_group(slot, gs, gs - $urandom_range(1, 3), pick_weight());
    end else if (sel < 49) begin
      load_group(slot, $urandom_range(0, 1) ? 0 : -1, $urandom_range(cur_len, 64),
                 pick_weight());
    end else begin
      gs = $urandom_range(1, cur_len);
      ge = gs + $urandom_range(0, 4);
      if (ge > cur_len) ge = cur_len;
      load_group(slot, gs, ge, pick_weight());
    end
  endtask

  task automatic wait_idle();
    while (cmd_q.size() > 0 || start || shrunk_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_length(logic [6:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    len_reg = val;
    cur_len = (val < 1) ? 1 : ((val > 64) ? 64 : int'(val));
  endtask

  initial begin
    int lens[7];
    int p, it, cnt, g, sel;
    lens = '{0, 127, 1, 5, 64, 12, 33};
    fails = 0;
    cycles = 0;
    steady = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    len_reg = LenReset;
    cur_len = 64;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill every store entry so no run reads an unwritten one.
    write_length(7'd64);
    for (int i = 0; i < 64; i++) load_elem(i, $urandom());
    for (int i = 0; i < 64; i++) load_group(i, 2, 1, pick_weight());

    // Directed: value extremes, root cases, errors and count limits.
    load_elem(0, 32'h7fff_ffff);
    load_elem(63, 32'h8000_0000);
    load_elem(1, 32'h0000_0000);
    run_shrink(0);
    load_group(0, -1, -1, 31'd0);
    run_shrink(1);
    load_group(0, -1, -1, 31'h7fff_ffff);
    run_shrink(1);
    load_group(0, -1, -1, 31'h0001_0000);
    load_group(1, 1, 64, 31'h0000_8000);
    load_group(2, 60, 64, 31'h7fff_ffff);
    load_group(3, 5, 4, 31'd7);
    run_shrink(4);
    run_shrink(64);
    load_group(0, -1, 3, 31'd1);
    run_shrink(1);
    load_group(0, 0, 3, 31'd1);
    run_shrink(1);
    load_group(0, 1, 65, 31'd1);
    run_shrink(1);
    begin
      in_word_t w;
      w = noise_word();
      w.op = OpUnused;
      cmd_q = {cmd_q, w};
    end
    load_group(0, 1, 0, 31'd0);
    run_shrink(2);

    // Random phases at several lengths; one phase runs with no idling.
    for (p = 0; p < 7; p++) begin
      wait_idle();
      write_length(lens[p][6:0]);
      steady = (p == 3);
      it = 0;
      while (it < 8) begin
        sel = $urandom_range(0, 99);
        cnt = (sel < 8) ? 64 : $urandom_range(0, 5);
        for (g = 0; g < cnt && g < 6; g++) begin
          random_group(g);
          it++;
        end
        for (g = $urandom_range(0, 3); g > 0; g--) begin
          load_elem($urandom_range(0, 63), $urandom());
          it++;
        end
        run_shrink(cnt);
        it++;
      end
    end

    wait_idle();
    repeat (200) @(posedge clk_i);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/tgs_pkg.sv
hdl/tgs_alu.sv
hdl/tree_group_shrink_top.sv
tb/tb_top.sv
